@@ rtl/gbe_pkg.sv @@
package gbe_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 3;

    localparam logic [7:0] MSB_MASK = 8'h80;

    // register indexes on the config port
    typedef enum logic [0:0] {
        REG_TEXT_COLOR  = 1'b0,
        REG_SCALE_SHIFT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [15:0] text_color;
        logic [1:0]  scale_shift;
    } cfg_t;

    // one byte's worth of pixel work handed from front to back
    typedef struct packed {
        logic [7:0]  bits;
        logic [10:0] x;
        logic [10:0] y;
        logic [1:0]  scale;
    } job_t;

endpackage

@@ rtl/gbe_in_if.sv @@
interface gbe_in_if;
    logic               valid;
    logic               ready;
    logic               glyph_start;
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic [7:0]         bitmap_byte;

    modport source (
        output valid, glyph_start, origin_x, origin_y, glyph_width, glyph_height,
               bitmap_byte,
        input  ready
    );
    modport sink (
        input  valid, glyph_start, origin_x, origin_y, glyph_width, glyph_height,
               bitmap_byte,
        output ready
    );
endinterface

@@ rtl/gbe_out_if.sv @@
interface gbe_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [15:0] pixel_color;
    logic        last_of_run;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_of_run,
        output ready
    );
endinterface

@@ rtl/gbe_regs.sv @@
module gbe_regs
    import gbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [15:0] text_color_reg;
    logic [1:0]  scale_shift_reg;
    logic        wr_en;
    reg_index_t  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg  <= '0;
            scale_shift_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_TEXT_COLOR:  text_color_reg  <= pwdata[15:0];
                REG_SCALE_SHIFT: scale_shift_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TEXT_COLOR:  prdata = {16'd0, text_color_reg};
            REG_SCALE_SHIFT: prdata = {30'd0, scale_shift_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.text_color  = text_color_reg;
    assign cfg.scale_shift = scale_shift_reg;

endmodule

@@ rtl/gbe_front.sv @@
module gbe_front
    import gbe_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    gbe_in_if.sink     glyph_in,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic        glyph_active_reg,   glyph_active_next;
    logic        glyph_rejected_reg, glyph_rejected_next;
    logic [7:0]  column_index_reg,   column_index_next;
    logic [7:0]  rows_left_reg,      rows_left_next;
    logic [2:0]  repeat_count_reg,   repeat_count_next;
    logic [11:0] current_x_reg,      current_x_next;
    logic [11:0] current_y_reg,      current_y_next;
    logic [11:0] saved_origin_x_reg, saved_origin_x_next;
    logic [7:0]  saved_width_reg,    saved_width_next;

    logic        accept;
    logic [1:0]  s;
    logic [10:0] w_scaled;
    logic [10:0] h_scaled;
    logic        x_fits;
    logic        y_fits;
    logic        bad;
    logic [7:0]  remain;
    logic        row_end;
    logic [3:0]  count;
    logic [7:0]  keep_mask;
    logic [7:0]  bits;
    logic [7:0]  rows_dec;

    assign glyph_in.ready = !q_full;
    assign accept = glyph_in.valid && glyph_in.ready;
    assign s      = cfg.scale_shift;

    // fit test on each axis, touching the last column or row is a reject
    assign w_scaled = 11'(glyph_in.glyph_width) << s;
    assign h_scaled = 11'(glyph_in.glyph_height) << s;
    assign x_fits = !glyph_in.origin_x[11] &&
                    ((13'(glyph_in.origin_x[10:0]) + 13'(w_scaled)) < 13'(SCREEN_WIDTH));
    assign y_fits = !glyph_in.origin_y[11] &&
                    ((13'(glyph_in.origin_y[10:0]) + 13'(h_scaled)) < 13'(SCREEN_HEIGHT));
    assign bad = (glyph_in.glyph_width == 8'd0) || (glyph_in.glyph_height == 8'd0) ||
                 !x_fits || !y_fits;

    // bits past the glyph width in the last byte of a row are dropped
    assign remain    = saved_width_reg - column_index_reg;
    assign row_end   = remain <= 8'd8;
    assign count     = row_end ? remain[3:0] : 4'd8;
    assign keep_mask = ~(8'hFF >> count);
    assign bits      = glyph_in.bitmap_byte & keep_mask;
    assign rows_dec  = rows_left_reg - 8'd1;

    assign push = accept && !glyph_in.glyph_start && glyph_active_reg && (bits != 8'd0);
    assign push_job.bits  = bits;
    assign push_job.x     = current_x_reg[10:0];
    assign push_job.y     = current_y_reg[10:0];
    assign push_job.scale = s;

    always_comb
    begin
        glyph_active_next   = glyph_active_reg;
        glyph_rejected_next = glyph_rejected_reg;
        column_index_next   = column_index_reg;
        rows_left_next      = rows_left_reg;
        repeat_count_next   = repeat_count_reg;
        current_x_next      = current_x_reg;
        current_y_next      = current_y_reg;
        saved_origin_x_next = saved_origin_x_reg;
        saved_width_next    = saved_width_reg;
        if (accept)
        begin
            if (glyph_in.glyph_start)
            begin
                column_index_next = '0;
                repeat_count_next = '0;
                if (bad)
                begin
                    glyph_active_next   = 1'b0;
                    glyph_rejected_next = 1'b1;
                    rows_left_next      = '0;
                end
                else
                begin
                    glyph_active_next   = 1'b1;
                    glyph_rejected_next = 1'b0;
                    rows_left_next      = glyph_in.glyph_height;
                    saved_width_next    = glyph_in.glyph_width;
                    saved_origin_x_next = glyph_in.origin_x;
                    current_x_next      = glyph_in.origin_x;
                    current_y_next      = glyph_in.origin_y;
                end
            end
            else if (glyph_active_reg)
            begin
                if (row_end)
                begin
                    column_index_next = '0;
                    current_x_next    = saved_origin_x_reg;
                    current_y_next    = current_y_reg + 12'd1;
                    if (repeat_count_reg >= {1'b0, s})
                    begin
                        repeat_count_next = '0;
                        rows_left_next    = rows_dec;
                        if (rows_dec == 8'd0)
                        begin
                            glyph_active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        repeat_count_next = repeat_count_reg + 3'd1;
                    end
                end
                else
                begin
                    column_index_next = column_index_reg + 8'd8;
                    current_x_next    = current_x_reg + (12'd8 << s);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_active_reg   <= 1'b0;
            glyph_rejected_reg <= 1'b0;
            column_index_reg   <= '0;
            rows_left_reg      <= '0;
            repeat_count_reg   <= '0;
            current_x_reg      <= '0;
            current_y_reg      <= '0;
            saved_origin_x_reg <= '0;
            saved_width_reg    <= '0;
        end
        else
        begin
            glyph_active_reg   <= glyph_active_next;
            glyph_rejected_reg <= glyph_rejected_next;
            column_index_reg   <= column_index_next;
            rows_left_reg      <= rows_left_next;
            repeat_count_reg   <= repeat_count_next;
            current_x_reg      <= current_x_next;
            current_y_reg      <= current_y_next;
            saved_origin_x_reg <= saved_origin_x_next;
            saved_width_reg    <= saved_width_next;
        end
    end

    a_active_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        !(glyph_active_reg && glyph_rejected_reg))
        else $error("glyph both active and rejected");

    a_col_inside_width: assert property (@(posedge clk) disable iff (!rst_n)
        glyph_active_reg |-> (column_index_reg < saved_width_reg))
        else $error("column index past glyph width");

endmodule

@@ rtl/gbe_queue.sv @@
module gbe_queue
    import gbe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

@@ rtl/gbe_back.sv @@
module gbe_back
    import gbe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    gbe_out_if.source pixel_out
);

    logic        busy_reg,    busy_next;
    logic        phase_reg,   phase_next;
    logic [7:0]  bits_reg,    bits_next;
    logic [10:0] x_reg,       x_next;
    logic [10:0] y_reg,       y_next;
    logic [1:0]  scale_reg,   scale_next;
    logic        ovalid_reg,  ovalid_next;
    logic [10:0] ox_reg,      ox_next;
    logic [10:0] oy_reg,      oy_next;
    logic [15:0] ocolor_reg,  ocolor_next;
    logic        olast_reg,   olast_next;

    logic        advance;
    logic        fire;
    logic [2:0]  idx;
    logic [7:0]  bits_cleared;
    logic        need_second;
    logic        emit_last;

    // leftmost set bit, msb first
    always_comb
    begin
        idx = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (bits_reg[7 - i])
            begin
                idx = 3'(i);
            end
        end
    end

    assign bits_cleared = bits_reg & ~(MSB_MASK >> idx);
    assign need_second  = (scale_reg != 2'd0) && !phase_reg;
    assign emit_last    = (bits_cleared == 8'd0) && !need_second;

    assign advance = !ovalid_reg || pixel_out.ready;
    assign fire    = busy_reg && advance;
    assign pop     = head_valid && advance && (!busy_reg || emit_last);

    always_comb
    begin
        busy_next   = busy_reg;
        phase_next  = phase_reg;
        bits_next   = bits_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        scale_next  = scale_reg;
        ovalid_next = ovalid_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ocolor_next = ocolor_reg;
        olast_next  = olast_reg;
        if (advance)
        begin
            ovalid_next = fire;
        end
        if (fire)
        begin
            // second write of a scaled bit lands one column to the right
            ox_next     = x_reg + (11'(idx) << scale_reg) + 11'(phase_reg);
            oy_next     = y_reg;
            ocolor_next = cfg.text_color;
            olast_next  = emit_last;
            if (need_second)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                bits_next  = bits_cleared;
            end
            if (emit_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            bits_next  = head_job.bits;
            x_next     = head_job.x;
            y_next     = head_job.y;
            scale_next = head_job.scale;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            phase_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg   <= bits_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        scale_reg  <= scale_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ocolor_reg <= ocolor_next;
        olast_reg  <= olast_next;
    end

    assign pixel_out.valid       = ovalid_reg;
    assign pixel_out.pixel_x     = ox_reg;
    assign pixel_out.pixel_y     = oy_reg;
    assign pixel_out.pixel_color = ocolor_reg;
    assign pixel_out.last_of_run = olast_reg;

    a_busy_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (bits_reg != 8'd0))
        else $error("busy with no bits left");

    a_unscaled_single: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (scale_reg == 2'd0)) |-> !phase_reg)
        else $error("second write on unscaled glyph");

endmodule

@@ rtl/glyph_bitmap_expander_unit.sv @@
// channel     dir  payload
// glyph_in    in   glyph_start, origin_x, origin_y, glyph_width, glyph_height, bitmap_byte
// pixel_out   out  pixel_x, pixel_y, pixel_color, last_of_run
// apb         in   text_color at 0x0, scale_shift at 0x4
//
// a bitmap byte yields one pixel write per set bit, up to 16 (8 bits, two writes
// each when scaled); the pixel output stage issues one write per cycle while not stalled
// start beats and bytes with no set bits in range are taken in the front and queue no job
// a 4-entry job queue lets the front keep taking beats while the back is busy
// or the pixel output is stalled; glyph_in.ready drops only when it is full
// rst_n is asynchronous, active low, and clears all control state
module glyph_bitmap_expander_unit
    import gbe_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    gbe_in_if.sink             glyph_in,
    gbe_out_if.source          pixel_out
);

    cfg_t cfg;
    logic push;
    job_t push_job;
    logic pop;
    logic q_full;
    logic head_valid;
    job_t head_job;

    gbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gbe_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .glyph_in (glyph_in),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    gbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    gbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .pixel_out  (pixel_out)
    );

endmodule
